// ----- rtl/core/wclmf_pkg.sv -----
package wclmf_pkg;

  // fixed field widths
  localparam int BRIGHT_W   = 8;
  localparam int TEMP_W     = 15;
  localparam int MIRED_W    = 16;
  localparam int FADE_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  // register reset values
  localparam logic [MIRED_W-1:0]  MIREDS_WARM_RST = 16'd454;
  localparam logic [MIRED_W-1:0]  MIREDS_COLD_RST = 16'd153;
  localparam logic [FADE_W-1:0]   FADE_FULL_RST   = 16'd1000;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX_RST  = 8'd254;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIREDS_WARM     = 2'd0,
    CFG_MIREDS_COLD     = 2'd1,
    CFG_FADE_FULL_SWING = 2'd2,
    CFG_BRIGHTNESS_MAX  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_TC,
    ST_DIV_BC,
    ST_MIX_MUL,
    ST_MIX,
    ST_FW_MUL,
    ST_FC_MUL,
    ST_FIN
  } st_t;

endpackage

// ----- rtl/core/wclmf_if.sv -----
interface wclmf_in_if;
  logic                              valid;
  logic                              ready;
  logic [wclmf_pkg::BRIGHT_W-1:0]    brightness;
  logic [wclmf_pkg::TEMP_W-1:0]      temperature;

  modport source (output valid, output brightness, output temperature, input ready);
  modport sink   (input valid, input brightness, input temperature, output ready);
endinterface

interface wclmf_out_if #(parameter int DUTY_BITS = 12);
  logic                              valid;
  logic                              ready;
  logic [DUTY_BITS:0]                warm_duty;
  logic [DUTY_BITS:0]                cold_duty;
  logic [wclmf_pkg::FADE_W-1:0]      fade_ms;

  modport source (output valid, output warm_duty, output cold_duty, output fade_ms,
                  input ready);
  modport sink   (input valid, input warm_duty, input cold_duty, input fade_ms,
                  output ready);
endinterface

// ----- rtl/core/warm_cold_led_mix_fade.sv -----
// Warm/cold LED mixer: each request (brightness, temperature in mireds) gives one result
// with the new warm and cold duty targets (2^DUTY_BITS is full on) and a fade time in ms.
// Brightness is saturated at brightness_max and scaled to full range, the temperature is
// clamped between the two mired bounds and mapped linearly onto 0..full; the channel on
// the far side of the neutral midpoint gets twice the scaled remainder, saturated at full.
// The fade time is the larger change against the previous duties times fade_full_swing,
// divided by full. A request runs through a single radix-2 divider that does the
// temperature and the brightness divisions one after the other, the temperature one
// skipped when the two bounds are equal, followed by four steps through one shared
// multiplier and a final step that waits for the output register. in_ch.ready is
// high only while the sequencer is idle; the result sits in an output register, so the
// next request can be taken while the previous result still waits. Configuration writes
// are taken at any time but must only be made while no request is in flight.
module warm_cold_led_mix_fade #(
  parameter int DUTY_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wclmf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wclmf_pkg::CFG_W-1:0]          cfg_wdata,
  wclmf_in_if.sink                             in_ch,
  wclmf_out_if.source                          out_ch
);

  // duty values run 0..FULL, so one bit wider than DUTY_BITS
  localparam int DW     = DUTY_BITS + 1;
  localparam int MB_W   = (DW > wclmf_pkg::FADE_W) ? DW : wclmf_pkg::FADE_W;
  localparam int PROD_W = DW + MB_W;
  localparam int CNT_W  = $clog2(DUTY_BITS + 1);
  localparam int MW     = wclmf_pkg::MIRED_W;
  localparam int BW     = wclmf_pkg::BRIGHT_W;
  localparam int FW     = wclmf_pkg::FADE_W;

  localparam logic [DW-1:0]    FULL     = DW'(1) << DUTY_BITS;
  localparam logic [DW-1:0]    HALF     = DW'(1) << (DUTY_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUTY_BITS);

  // configuration registers
  logic [MW-1:0] mireds_warm_r;
  logic [MW-1:0] mireds_cold_r;
  logic [FW-1:0] fade_full_r;
  logic [BW-1:0] bright_max_r;

  // sequencer
  wclmf_pkg::st_t state_r, state_nxt;

  // request and prepared operands
  logic [BW-1:0]                 b_raw_r;
  logic [wclmf_pkg::TEMP_W-1:0]  t_raw_r;
  logic [MW-1:0]                 dx_r;      // clamped temperature minus cold bound
  logic [MW-1:0]                 span_r;    // warm bound minus cold bound
  logic [BW-1:0]                 bx_r;      // saturated brightness
  logic [BW-1:0]                 bd_r;      // brightness max, never zero
  logic                          warm_side_r;

  // shared divider
  logic [MW-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;

  // intermediate results
  logic [DW-1:0]     tc_r;
  logic [DW-1:0]     bc_r;
  logic [PROD_W-1:0] prod_r;
  logic [DW-1:0]     warm_new_r;
  logic [DW-1:0]     cold_new_r;
  logic [FW-1:0]     fw_r;

  // channel state and output register
  logic [DW-1:0] warm_now_r;
  logic [DW-1:0] cold_now_r;
  logic          out_valid_r;
  logic [DW-1:0] out_warm_r;
  logic [DW-1:0] out_cold_r;
  logic [FW-1:0] out_fade_r;

  // sequencer decodes
  logic in_acc;
  logic div_on;
  logic div_done;
  logic out_load;

  // ------------------------------------------------------------------
  // prep: clamp brightness and temperature, order the bounds
  // ------------------------------------------------------------------
  logic [MW-1:0]   lo_c, hi_c, t_ext_c, t_cl_c, neutral_c;
  logic [MW:0]     bound_sum_c;
  logic [BW-1:0]   bmax_c, b_cl_c;

  always_comb begin
    lo_c        = (mireds_cold_r < mireds_warm_r) ? mireds_cold_r : mireds_warm_r;
    hi_c        = (mireds_cold_r < mireds_warm_r) ? mireds_warm_r : mireds_cold_r;
    bound_sum_c = {1'b0, lo_c} + {1'b0, hi_c};
    neutral_c   = bound_sum_c[MW:1];
    t_ext_c     = MW'(t_raw_r);
    if (t_ext_c < lo_c) begin
      t_cl_c = lo_c;
    end else if (t_ext_c > hi_c) begin
      t_cl_c = hi_c;
    end else begin
      t_cl_c = t_ext_c;
    end
    bmax_c = (bright_max_r == '0) ? BW'(1) : bright_max_r;
    b_cl_c = (b_raw_r > bmax_c) ? bmax_c : b_raw_r;
  end

  // ------------------------------------------------------------------
  // shared divider step: quotient of x * 2^DUTY_BITS / d with x <= d,
  // one quotient bit per cycle, msb first
  // ------------------------------------------------------------------
  logic [MW-1:0] div_x_c, div_d_c;
  logic [MW:0]   div_sh_c, div_sub_c;
  logic          div_ge_c;
  logic [MW-1:0] rem_nxt;
  logic [DW-1:0] quo_nxt;

  always_comb begin
    if (state_r == wclmf_pkg::ST_DIV_TC) begin
      div_x_c = dx_r;
      div_d_c = span_r;
    end else begin
      div_x_c = MW'(bx_r);
      div_d_c = MW'(bd_r);
    end
    // first step compares x itself, later steps the doubled remainder
    div_sh_c  = (cnt_r == CNT_LAST) ? {1'b0, div_x_c} : {rem_r, 1'b0};
    div_sub_c = div_sh_c - {1'b0, div_d_c};
    div_ge_c  = (div_sh_c >= {1'b0, div_d_c});
    rem_nxt   = div_ge_c ? div_sub_c[MW-1:0] : div_sh_c[MW-1:0];
    quo_nxt   = {quo_r[DW-2:0], div_ge_c};
  end

  // ------------------------------------------------------------------
  // shared multiplier operands
  // ------------------------------------------------------------------
  logic [DW-1:0]     mul_a_c;
  logic [MB_W-1:0]   mul_b_c;
  logic [DW-1:0]     diff_w_c, diff_c_c;
  logic [PROD_W-1:0] mix_sh_c;
  logic [DW-1:0]     mix_c;
  logic [FW-1:0]     fade_cur_c;

  always_comb begin
    diff_w_c = (warm_now_r > warm_new_r) ? (warm_now_r - warm_new_r)
                                         : (warm_new_r - warm_now_r);
    diff_c_c = (cold_now_r > cold_new_r) ? (cold_now_r - cold_new_r)
                                         : (cold_new_r - cold_now_r);
    unique case (state_r)
      wclmf_pkg::ST_MIX_MUL: begin
        mul_a_c = warm_side_r ? (FULL - tc_r) : tc_r;
        mul_b_c = MB_W'(bc_r);
      end
      wclmf_pkg::ST_FW_MUL: begin
        mul_a_c = diff_w_c;
        mul_b_c = MB_W'(fade_full_r);
      end
      wclmf_pkg::ST_FC_MUL: begin
        mul_a_c = diff_c_c;
        mul_b_c = MB_W'(fade_full_r);
      end
      default: begin
        mul_a_c = '0;
        mul_b_c = '0;
      end
    endcase
    // 2 * p / FULL, saturated at full
    mix_sh_c   = prod_r >> (DUTY_BITS - 1);
    mix_c      = (mix_sh_c > PROD_W'(FULL)) ? FULL : mix_sh_c[DW-1:0];
    // p / FULL for the fade time
    fade_cur_c = prod_r[DUTY_BITS +: FW];
  end

  // ------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wclmf_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = wclmf_pkg::ST_PREP;
      end
      wclmf_pkg::ST_PREP: begin
        // equal bounds: neutral, no temperature division
        state_nxt = (hi_c == lo_c) ? wclmf_pkg::ST_DIV_BC : wclmf_pkg::ST_DIV_TC;
      end
      wclmf_pkg::ST_DIV_TC: begin
        if (div_done) state_nxt = wclmf_pkg::ST_DIV_BC;
      end
      wclmf_pkg::ST_DIV_BC: begin
        if (div_done) state_nxt = wclmf_pkg::ST_MIX_MUL;
      end
      wclmf_pkg::ST_MIX_MUL: state_nxt = wclmf_pkg::ST_MIX;
      wclmf_pkg::ST_MIX:     state_nxt = wclmf_pkg::ST_FW_MUL;
      wclmf_pkg::ST_FW_MUL:  state_nxt = wclmf_pkg::ST_FC_MUL;
      wclmf_pkg::ST_FC_MUL:  state_nxt = wclmf_pkg::ST_FIN;
      wclmf_pkg::ST_FIN: begin
        if (out_load) state_nxt = wclmf_pkg::ST_IDLE;
      end
      default: state_nxt = wclmf_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer: decodes
  // ------------------------------------------------------------------
  always_comb begin
    in_ch.ready = (state_r == wclmf_pkg::ST_IDLE);
    in_acc      = in_ch.valid && in_ch.ready;
    div_on      = (state_r == wclmf_pkg::ST_DIV_TC) || (state_r == wclmf_pkg::ST_DIV_BC);
    div_done    = div_on && (cnt_r == '0);
    // result register frees up when empty or taken this cycle
    out_load    = (state_r == wclmf_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.warm_duty = out_warm_r;
  assign out_ch.cold_duty = out_cold_r;
  assign out_ch.fade_ms   = out_fade_r;

  // ------------------------------------------------------------------
  // control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= wclmf_pkg::ST_IDLE;
      cnt_r         <= CNT_LAST;
      out_valid_r   <= 1'b0;
      warm_now_r    <= '0;
      cold_now_r    <= '0;
      mireds_warm_r <= wclmf_pkg::MIREDS_WARM_RST;
      mireds_cold_r <= wclmf_pkg::MIREDS_COLD_RST;
      fade_full_r   <= wclmf_pkg::FADE_FULL_RST;
      bright_max_r  <= wclmf_pkg::BRIGHT_MAX_RST;
    end else begin
      state_r <= state_nxt;
      if (div_on) begin
        cnt_r <= div_done ? CNT_LAST : (cnt_r - CNT_W'(1));
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        warm_now_r  <= warm_new_r;
        cold_now_r  <= cold_new_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (wclmf_pkg::cfg_idx_t'(cfg_addr))
          wclmf_pkg::CFG_MIREDS_WARM:     mireds_warm_r <= cfg_wdata;
          wclmf_pkg::CFG_MIREDS_COLD:     mireds_cold_r <= cfg_wdata;
          wclmf_pkg::CFG_FADE_FULL_SWING: fade_full_r   <= cfg_wdata;
          wclmf_pkg::CFG_BRIGHTNESS_MAX:  bright_max_r  <= cfg_wdata[BW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_raw_r <= in_ch.brightness;
      t_raw_r <= in_ch.temperature;
    end
    if (state_r == wclmf_pkg::ST_PREP) begin
      dx_r        <= t_cl_c - lo_c;
      span_r      <= hi_c - lo_c;
      bx_r        <= b_cl_c;
      bd_r        <= bmax_c;
      warm_side_r <= (t_cl_c >= neutral_c);
      tc_r        <= HALF;
    end
    if (div_on) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (div_done && (state_r == wclmf_pkg::ST_DIV_TC)) tc_r <= quo_nxt;
    if (div_done && (state_r == wclmf_pkg::ST_DIV_BC)) bc_r <= quo_nxt;
    // cold channel product is held while the result waits for a free output register
    if (state_r != wclmf_pkg::ST_FIN) prod_r <= PROD_W'(mul_a_c) * PROD_W'(mul_b_c);
    if (state_r == wclmf_pkg::ST_MIX) begin
      warm_new_r <= warm_side_r ? bc_r : mix_c;
      cold_new_r <= warm_side_r ? mix_c : bc_r;
    end
    if (state_r == wclmf_pkg::ST_FC_MUL) fw_r <= fade_cur_c;
    if (out_load) begin
      out_warm_r <= warm_new_r;
      out_cold_r <= cold_new_r;
      out_fade_r <= (fw_r > fade_cur_c) ? fw_r : fade_cur_c;
    end
  end

`ifndef ASSERT_OFF
  // divider counter rests at its start value outside the division steps
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !div_on |-> cnt_r == CNT_LAST)
    else $error("divider counter not parked outside division");

  // both division quotients are within full scale before mixing
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wclmf_pkg::ST_MIX_MUL |-> (tc_r <= FULL) && (bc_r <= FULL))
    else $error("division quotient above full scale");

  // remembered duties never exceed full scale
  a_now_range: assert property (@(posedge clk) disable iff (!rst_n)
    (warm_now_r <= FULL) && (cold_now_r <= FULL))
    else $error("channel duty above full scale");

  // a loaded result matches the remembered duties
  a_load_now: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (out_warm_r == warm_now_r) && (out_cold_r == cold_now_r))
    else $error("result and channel state disagree");

  // an accepted request always goes to operand preparation
  a_acc_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == wclmf_pkg::ST_PREP)
    else $error("accepted request not started");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int DUTY_BITS = 12;
  // run length of one request through the sequencer, in cycles
  localparam int REQ_LATENCY = 2 * DUTY_BITS + 8;
  localparam int MAX_IDLE = 13;

  // one result as the block presents it
  typedef struct packed {
    logic [DUTY_BITS:0]             warm_duty;
    logic [DUTY_BITS:0]             cold_duty;
    logic [wclmf_pkg::FADE_W-1:0]   fade_ms;
  } duty_result_t;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [wclmf_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [wclmf_pkg::CFG_W-1:0]      cfg_wdata;

  wclmf_in_if in_ch ();
  wclmf_out_if #(.DUTY_BITS(DUTY_BITS)) out_ch ();

  warm_cold_led_mix_fade #(
    .DUTY_BITS(DUTY_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow copy of the registers, tracked on every write
  logic [wclmf_pkg::MIRED_W-1:0]  mired_warm_cfg;
  logic [wclmf_pkg::MIRED_W-1:0]  mired_cold_cfg;
  logic [wclmf_pkg::FADE_W-1:0]   fade_swing_cfg;
  logic [wclmf_pkg::BRIGHT_W-1:0] bright_max_cfg;

  // duties left behind by the last accepted request
  logic [DUTY_BITS:0] warm_level;
  logic [DUTY_BITS:0] cold_level;

  duty_result_t duty_queue[$];   // results still owed by the block
  int errors;
  bit idle_off;                  // both sides run without gaps while set
  int hold_cycles;               // receiver holds ready low this long once

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: duty targets and fade time for one request
  // ---------------------------------------------------------------------------
  function automatic duty_result_t mix_duties(input logic [wclmf_pkg::BRIGHT_W-1:0] b_in,
                                              input logic [wclmf_pkg::TEMP_W-1:0] t_in);
    logic [63:0] full, b, t, bmax, lo, hi, mid, tc, bc, warm, cold, fw, fc, dw, dc;
    duty_result_t r;
    full = 64'd1 << DUTY_BITS;
    b = 64'(b_in);
    t = 64'(t_in);
    // a zero maximum behaves as one
    bmax = (bright_max_cfg == 0) ? 64'd1 : 64'(bright_max_cfg);
    // swapped bounds: the lower one is always the cold side
    lo = (mired_cold_cfg < mired_warm_cfg) ? 64'(mired_cold_cfg) : 64'(mired_warm_cfg);
    hi = (mired_cold_cfg < mired_warm_cfg) ? 64'(mired_warm_cfg) : 64'(mired_cold_cfg);
    mid = (lo + hi) / 2;
    if (b > bmax) b = bmax;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    // equal bounds sit at neutral
    tc = (hi == lo) ? full / 2 : (t - lo) * full / (hi - lo);
    bc = b * full / bmax;
    if (t >= mid) begin
      warm = bc;
      cold = 2 * (full - tc) * bc / full;
    end else begin
      cold = bc;
      warm = 2 * tc * bc / full;
    end
    if (warm > full) warm = full;
    if (cold > full) cold = full;
    dw = (warm_level > warm) ? warm_level - warm : warm - warm_level;
    dc = (cold_level > cold) ? cold_level - cold : cold - cold_level;
    fw = dw * fade_swing_cfg / full;
    fc = dc * fade_swing_cfg / full;
    r.warm_duty = warm[DUTY_BITS:0];
    r.cold_duty = cold[DUTY_BITS:0];
    r.fade_ms   = (fw > fc) ? fw[wclmf_pkg::FADE_W-1:0] : fc[wclmf_pkg::FADE_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // one register write, shadow updated at the accepting edge
  task automatic write_reg(input wclmf_pkg::cfg_idx_t idx,
                           input logic [wclmf_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      wclmf_pkg::CFG_MIREDS_WARM:     mired_warm_cfg = data;
      wclmf_pkg::CFG_MIREDS_COLD:     mired_cold_cfg = data;
      wclmf_pkg::CFG_FADE_FULL_SWING: fade_swing_cfg = data;
      wclmf_pkg::CFG_BRIGHTNESS_MAX:  bright_max_cfg = data[wclmf_pkg::BRIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // rewrite all four registers, only while the block is idle
  task automatic load_config(input logic [wclmf_pkg::MIRED_W-1:0] warm,
                             input logic [wclmf_pkg::MIRED_W-1:0] cold,
                             input logic [wclmf_pkg::FADE_W-1:0] swing,
                             input logic [wclmf_pkg::BRIGHT_W-1:0] bmax);
    write_reg(wclmf_pkg::CFG_MIREDS_WARM, warm);
    write_reg(wclmf_pkg::CFG_MIREDS_COLD, cold);
    write_reg(wclmf_pkg::CFG_FADE_FULL_SWING, swing);
    write_reg(wclmf_pkg::CFG_BRIGHTNESS_MAX, {8'd0, bmax});
    cfg_we <= 1'b0;
  endtask

  // offer one request after a random gap, predict it once it is taken
  task automatic send_request(input logic [wclmf_pkg::BRIGHT_W-1:0] b,
                              input logic [wclmf_pkg::TEMP_W-1:0] t);
    int gap;
    duty_result_t predicted;
    gap = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.brightness  <= b;
    in_ch.temperature <= t;
    do @(posedge clk); while (!in_ch.ready);
    predicted = mix_duties(b, t);
    duty_queue.push_back(predicted);
    warm_level = predicted.warm_duty;
    cold_level = predicted.cold_duty;
  endtask

  // sender pauses until every owed result has come back
  task automatic drain;
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold when a test asks for it
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    duty_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_queue.size() == 0) begin
        $error("unexpected result: warm_duty %0d cold_duty %0d fade_ms %0d",
               out_ch.warm_duty, out_ch.cold_duty, out_ch.fade_ms);
        errors++;
      end else begin
        want = duty_queue.pop_front();
        if (out_ch.warm_duty !== want.warm_duty) begin
          $error("warm_duty: expected %0d, actual %0d", want.warm_duty, out_ch.warm_duty);
          errors++;
        end
        if (out_ch.cold_duty !== want.cold_duty) begin
          $error("cold_duty: expected %0d, actual %0d", want.cold_duty, out_ch.cold_duty);
          errors++;
        end
        if (out_ch.fade_ms !== want.fade_ms) begin
          $error("fade_ms: expected %0d, actual %0d", want.fade_ms, out_ch.fade_ms);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: 153..454 mireds, neutral at 303
  task automatic test_reset_defaults;
    send_request(8'd0, 15'd0);          // dark, far below the cold bound
    send_request(8'd255, 15'd32767);    // brightness over max, far above warm bound
    send_request(8'd254, 15'd153);      // exact cold bound, full brightness
    send_request(8'd254, 15'd454);      // exact warm bound
    send_request(8'd200, 15'd303);      // exact neutral point goes the warm way
    send_request(8'd200, 15'd302);      // one below neutral
    send_request(8'd127, 15'd300);
    send_request(8'd1, 15'd200);
    drain;
  endtask

  // register corner settings, a few requests each
  task automatic test_register_corners;
    // swapped bounds
    load_config(16'd153, 16'd454, 16'd1000, 8'd254);
    send_request(8'd254, 15'd160);
    send_request(8'd254, 15'd440);
    send_request(8'd90, 15'd303);
    drain;
    // equal bounds: neutral, both channels get the scaled brightness
    load_config(16'd300, 16'd300, 16'd2500, 8'd100);
    send_request(8'd100, 15'd12);
    send_request(8'd33, 15'd300);
    send_request(8'd200, 15'd32767);
    drain;
    // widest bounds, longest fade, largest maximum
    load_config(16'hffff, 16'h0000, 16'hffff, 8'd255);
    send_request(8'd255, 15'd0);
    send_request(8'd255, 15'd32767);
    send_request(8'd0, 15'd16384);
    drain;
    // smallest settings: zero bounds, no fade, maximum of one
    load_config(16'h0000, 16'h0000, 16'h0000, 8'd1);
    send_request(8'd1, 15'd5);
    send_request(8'd0, 15'd0);
    send_request(8'd255, 15'd32767);
    drain;
    // zero maximum behaves as one
    load_config(16'd500, 16'd100, 16'd4096, 8'd0);
    send_request(8'd1, 15'd150);
    send_request(8'd0, 15'd450);
    send_request(8'd77, 15'd299);
    drain;
  endtask

  // random request for the current bounds, mostly inside them
  task automatic send_random_request;
    int lo, hi, t, b, bmax;
    lo = (mired_cold_cfg < mired_warm_cfg) ? int'(mired_cold_cfg) : int'(mired_warm_cfg);
    hi = (mired_cold_cfg < mired_warm_cfg) ? int'(mired_warm_cfg) : int'(mired_cold_cfg);
    bmax = (bright_max_cfg == 0) ? 1 : int'(bright_max_cfg);
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, 32767);
      1: t = $urandom_range(0, 1) ? lo : hi;
      2: t = (lo + hi) / 2 + $urandom_range(0, 2) - 1;
      default: t = (lo > 32767) ? $urandom_range(0, 32767) : $urandom_range(lo, hi);
    endcase
    if (t < 0) t = 0;
    if (t > 32767) t = 32767;
    case ($urandom_range(0, 9))
      0, 1: b = $urandom_range(0, 255);
      2:    b = $urandom_range(0, 1) ? bmax : 0;
      default: b = $urandom_range(0, bmax);
    endcase
    send_request(b[wclmf_pkg::BRIGHT_W-1:0], t[wclmf_pkg::TEMP_W-1:0]);
  endtask

  // random settings per phase, random requests within each
  task automatic test_random_mix;
    int cold, warm;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0: begin
          cold = $urandom_range(100, 250);
          warm = $urandom_range(300, 600);
        end
        1: begin
          warm = $urandom_range(100, 250);
          cold = $urandom_range(300, 600);
        end
        2: begin
          cold = $urandom_range(0, 65535);
          warm = $urandom_range(0, 65535);
        end
        3: begin
          cold = $urandom_range(0, 32767);
          warm = cold;
        end
        default: begin
          cold = $urandom_range(0, 32000);
          warm = cold + $urandom_range(1, 8);
        end
      endcase
      load_config(warm[15:0], cold[15:0], 16'($urandom_range(0, 65535)),
                  8'($urandom_range(1, 255)));
      repeat (140) send_random_request();
      drain;
    end
  endtask

  // receiver holds off a long time while requests keep coming, block stalls its input
  task automatic test_back_pressure;
    load_config(16'd454, 16'd153, 16'd1000, 8'd254);
    repeat (2) begin
      idle_off = 1'b1;
      hold_cycles = 400;
      repeat (10) send_random_request();
      drain;
      idle_off = 1'b0;
      repeat (10) send_random_request();
      drain;
    end
  endtask

  // back-to-back stretch on both sides
  task automatic test_full_rate;
    load_config(16'd500, 16'd140, 16'($urandom_range(0, 65535)),
                8'($urandom_range(1, 255)));
    idle_off = 1'b1;
    repeat (120) send_random_request();
    drain;
    idle_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = wclmf_pkg::CFG_MIREDS_WARM;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.brightness = '0;
    in_ch.temperature = '0;
    errors = 0;
    idle_off = 1'b0;
    hold_cycles = 0;
    // shadow state starts at the reset values
    mired_warm_cfg = wclmf_pkg::MIREDS_WARM_RST;
    mired_cold_cfg = wclmf_pkg::MIREDS_COLD_RST;
    fade_swing_cfg = wclmf_pkg::FADE_FULL_RST;
    bright_max_cfg = wclmf_pkg::BRIGHT_MAX_RST;
    warm_level = '0;
    cold_level = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_random_mix();
    test_back_pressure();
    test_full_rate();

    // all taken and returned: watch a little longer for stray results
    drain;
    repeat (2 * REQ_LATENCY) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
